// ===== rtl/gmwis_pkg.sv =====
// Shared types and constants for the greedy independent-set block.
package gmwis_pkg;
    localparam int DEF_MAX_NODES = 64;
    localparam int WEIGHT_W = 32;
    localparam int SUM_W = 38;
    localparam int COST_W = 39;
    localparam logic signed [31:0] THRESH_RESET = -32'sd17;
    localparam logic [COST_W-1:0] ONE_Q24 = 39'd16777216;

    // Insertion chain control, broadcast to every cell.
    typedef struct packed {
        logic       ins;    // insert a new key this cycle
        logic       shift;  // walk the sorted chain out by one
    } cell_ctl_t;
endpackage

// ===== rtl/greedy_max_weight_independent_set.sv =====
// Top level: load, chain sort, greedy walk and result output.
// Nodes load one per cycle into a weight/row memory and, at the same time,
// into a chain of MAX_NODES cells that keeps them sorted heaviest first (ties
// to the lower index). After the item with last_node, the chain shifts out
// one node per cycle; each shifted node's row is read from memory and tested
// against the chosen mask; the chosen nodes are recorded in the order they
// were taken. A decision state then compares the cost with the threshold.
// Results leave one at a time, each chosen node after a registered read of
// its record, or a single not-found result, and the receiver may stall them.
// No input is taken from the last node until the last result is delivered.
module greedy_max_weight_independent_set #(
    parameter int MAX_NODES = gmwis_pkg::DEF_MAX_NODES
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // [31:0] weight, [95:32] adjacency_row
    input  logic [95:0]  s_tdata,
    input  logic         s_tlast,
    output logic         m_tvalid,
    input  logic         m_tready,
    // [5:0] chosen_node, [44:6] reduced_cost, zero fill to 48
    output logic [47:0]  m_tdata,
    // found
    output logic         m_tuser,
    output logic         m_tlast,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [1:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);
    import gmwis_pkg::*;
    localparam int IDX_W = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int CNT_W = $clog2(MAX_NODES + 1);
    localparam logic [CNT_W-1:0] MAXN = CNT_W'(MAX_NODES);

    localparam logic [2:0] S_LOAD = 3'd0, S_WALK = 3'd1, S_DEC = 3'd2,
                           S_EMIT = 3'd3, S_NF = 3'd4;

    // config
    logic signed [31:0] thr_reg;
    assign pready = 1'b1;
    assign prdata = thr_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) thr_reg <= THRESH_RESET;
        else if (psel && penable && pwrite && paddr == 2'd0) thr_reg <= pwdata;
    end

    logic [2:0]        st_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [MAX_NODES-1:0] chosen_reg, valid_reg;
    logic [SUM_W-1:0]  sum_reg;
    logic [COST_W-1:0] cost_reg;
    logic              rd_v_reg;      // memory read in flight
    logic [IDX_W-1:0]  rd_i_reg;
    logic [CNT_W-1:0]  pick_cnt_reg;  // chosen nodes recorded so far
    logic [CNT_W-1:0]  ptr_reg;       // next recorded node to emit
    logic [CNT_W-1:0]  left_reg;      // chosen nodes still to emit
    logic              cur_v_reg;

    // node memory
    logic [WEIGHT_W-1:0]  wmem [MAX_NODES];
    logic [MAX_NODES-1:0] amem [MAX_NODES];
    logic [WEIGHT_W-1:0]  rd_w_reg;
    logic [MAX_NODES-1:0] rd_a_reg;

    // chosen nodes in walk order
    logic [IDX_W-1:0] pick_mem [MAX_NODES];
    logic [IDX_W-1:0] pick_rd_reg;

    logic acc_in;
    assign s_tready = (st_reg == S_LOAD);
    assign acc_in = s_tvalid && s_tready;
    logic store;
    assign store = acc_in && (cnt_reg < MAXN);
    logic [CNT_W-1:0] n_load;
    assign n_load = store ? cnt_reg + 1'b1 : cnt_reg;

    // chain: entry k holds the outputs of cell k-1; entries 0 and
    // MAX_NODES+1 are the empty ends
    cell_ctl_t ctl;
    logic clr;
    logic [MAX_NODES+1:0] e_full;
    logic [MAX_NODES:0]   e_after;
    logic [WEIGHT_W-1:0]  e_w [MAX_NODES+2];
    logic [IDX_W-1:0]     e_i [MAX_NODES+2];
    assign e_full[0] = 1'b0;
    assign e_after[0] = 1'b1;
    assign e_w[0] = '0;
    assign e_i[0] = '0;
    assign e_full[MAX_NODES+1] = 1'b0;
    assign e_w[MAX_NODES+1] = '0;
    assign e_i[MAX_NODES+1] = '0;

    genvar g;
    generate
        for (g = 0; g < MAX_NODES; g++) begin : g_cell
            gmwis_cell #(.IDX_W(IDX_W)) u_cell (
                .aclk(aclk), .aresetn(aresetn), .ctl(ctl), .clr(clr),
                .new_w(s_tdata[31:0]), .new_i(cnt_reg[IDX_W-1:0]),
                .left_full(e_full[g]), .left_goes_after(e_after[g]),
                .left_w(e_w[g]), .left_i(e_i[g]),
                .right_full(e_full[g+2]), .right_w(e_w[g+2]), .right_i(e_i[g+2]),
                .full(e_full[g+1]), .goes_after(e_after[g+1]),
                .w(e_w[g+1]), .idx(e_i[g+1])
            );
        end
    endgenerate

    // head cell outputs
    logic head_full;
    logic [IDX_W-1:0] head_i;
    assign head_full = e_full[1];
    assign head_i = e_i[1];

    always_comb begin
        ctl.ins = store;
        ctl.shift = (st_reg == S_WALK) && head_full;
        clr = 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (store) begin
            wmem[cnt_reg[IDX_W-1:0]] <= s_tdata[31:0];
            amem[cnt_reg[IDX_W-1:0]] <= s_tdata[32 +: MAX_NODES];
        end
        rd_w_reg <= wmem[head_i];
        rd_a_reg <= amem[head_i];
    end

    logic [MAX_NODES-1:0] row_eff;
    assign row_eff = rd_a_reg & valid_reg & ~(MAX_NODES'(1) << rd_i_reg);
    logic pick_we;
    assign pick_we = (st_reg == S_WALK) && rd_v_reg && ((row_eff & chosen_reg) == '0);

    always_ff @(posedge aclk) begin
        if (pick_we) pick_mem[pick_cnt_reg[IDX_W-1:0]] <= rd_i_reg;
        pick_rd_reg <= pick_mem[ptr_reg[IDX_W-1:0]];
    end

    logic signed [COST_W-1:0] cost_s;
    assign cost_s = ONE_Q24 - {1'b0, sum_reg};
    logic signed [COST_W-1:0] thr_ext;
    assign thr_ext = {{(COST_W-32){thr_reg[31]}}, thr_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= S_LOAD;
            cnt_reg <= '0;
            rd_v_reg <= 1'b0;
            cur_v_reg <= 1'b0;
        end else begin
            unique case (st_reg)
                S_LOAD: begin
                    if (acc_in) begin
                        if (store) cnt_reg <= cnt_reg + 1'b1;
                        if (s_tlast) begin
                            st_reg <= S_WALK;
                            valid_reg <= (n_load >= MAXN)
                                ? '1 : ((MAX_NODES'(1) << n_load) - 1'b1);
                            chosen_reg <= '0;
                            sum_reg <= '0;
                            pick_cnt_reg <= '0;
                        end
                    end
                end
                S_WALK: begin
                    rd_v_reg <= head_full;
                    rd_i_reg <= head_i;
                    if (pick_we) begin
                        chosen_reg[rd_i_reg] <= 1'b1;
                        sum_reg <= sum_reg + SUM_W'(rd_w_reg);
                        pick_cnt_reg <= pick_cnt_reg + 1'b1;
                    end
                    if (!head_full && !rd_v_reg) st_reg <= S_DEC;
                end
                S_DEC: begin
                    cost_reg <= cost_s;
                    cnt_reg <= '0;
                    ptr_reg <= '0;
                    cur_v_reg <= 1'b0;
                    left_reg <= pick_cnt_reg;
                    st_reg <= (cost_s < thr_ext) ? S_EMIT : S_NF;
                end
                S_EMIT: begin
                    // first wait for the registered read, then hold for output
                    if (!cur_v_reg) begin
                        cur_v_reg <= 1'b1;
                    end else if (m_tready) begin
                        cur_v_reg <= 1'b0;
                        ptr_reg <= ptr_reg + 1'b1;
                        left_reg <= left_reg - 1'b1;
                        if (left_reg == CNT_W'(1)) st_reg <= S_LOAD;
                    end
                end
                S_NF: begin
                    if (m_tready) st_reg <= S_LOAD;
                end
                default: st_reg <= S_LOAD;
            endcase
        end
    end

    assign m_tvalid = (st_reg == S_NF) || (st_reg == S_EMIT && cur_v_reg);
    assign m_tuser = (st_reg == S_EMIT);
    assign m_tlast = (st_reg == S_NF) || (left_reg == CNT_W'(1));
    assign m_tdata = {3'b0, cost_reg,
                      (st_reg == S_EMIT) ? 6'(pick_rd_reg) : 6'd0};
endmodule

// ===== rtl/gmwis_cell.sv =====
// One cell of the sorted insertion chain: holds a weight and a node index.
module gmwis_cell #(
    parameter int IDX_W = 6
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  gmwis_pkg::cell_ctl_t          ctl,
    input  logic                          clr,
    input  logic [gmwis_pkg::WEIGHT_W-1:0] new_w,
    input  logic [IDX_W-1:0]              new_i,
    // from the left (heavier) neighbor
    input  logic                          left_full,
    input  logic                          left_goes_after,
    input  logic [gmwis_pkg::WEIGHT_W-1:0] left_w,
    input  logic [IDX_W-1:0]              left_i,
    // from the right neighbor, used during shift-out
    input  logic                          right_full,
    input  logic [gmwis_pkg::WEIGHT_W-1:0] right_w,
    input  logic [IDX_W-1:0]              right_i,
    output logic                          full,
    output logic                          goes_after,
    output logic [gmwis_pkg::WEIGHT_W-1:0] w,
    output logic [IDX_W-1:0]              idx
);
    import gmwis_pkg::*;
    logic                full_reg, full_next;
    logic [WEIGHT_W-1:0] w_reg, w_next;
    logic [IDX_W-1:0]    i_reg, i_next;

    // new key sorts after this one: lower weight, or equal (later index)
    assign goes_after = full_reg && (new_w <= w_reg);
    assign full = full_reg;
    assign w = w_reg;
    assign idx = i_reg;

    always_comb begin
        full_next = full_reg;
        w_next = w_reg;
        i_next = i_reg;
        if (clr) begin
            full_next = 1'b0;
        end else if (ctl.shift) begin
            full_next = right_full;
            w_next = right_w;
            i_next = right_i;
        end else if (ctl.ins && !goes_after) begin
            if (left_goes_after) begin
                full_next = 1'b1;
                w_next = new_w;
                i_next = new_i;
            end else begin
                full_next = left_full;
                w_next = left_w;
                i_next = left_i;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            full_reg <= 1'b0;
        end else begin
            full_reg <= full_next;
        end
        w_reg <= w_next;
        i_reg <= i_next;
    end
endmodule

// ===== dv/greedy_max_weight_independent_set_tb.sv =====
// Testbench for the greedy maximum-weight independent set block.
`timescale 1ns / 100ps

module greedy_max_weight_independent_set_tb;
    import gmwis_pkg::*;

    localparam int NODES = DEF_MAX_NODES;
    localparam logic [1:0] THRESH_ADDR = 2'd0;

    typedef struct packed {
        logic [31:0] weight;
        logic [63:0] row;
        logic        last;
    } node_req_t;

    typedef struct packed {
        logic                found;
        logic [5:0]          node;
        logic [COST_W-1:0]   cost;
        logic                last;
    } set_result_t;

    logic aclk = 0;
    logic aresetn = 0;
    logic s_tvalid = 0;
    logic s_tready;
    logic [95:0] s_tdata = '0;
    logic s_tlast = 0;
    logic m_tvalid;
    logic m_tready = 0;
    logic [47:0] m_tdata;
    logic m_tuser;
    logic m_tlast;
    logic psel = 0, penable = 0, pwrite = 0;
    logic [1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    greedy_max_weight_independent_set DUT (.*);

    always #5 aclk = ~aclk;

    // predictor state
    logic [31:0] node_w [NODES];
    logic [63:0] node_row [NODES];
    int unsigned stored_nodes = 0;
    logic signed [31:0] cost_limit = THRESH_RESET;

    node_req_t   pending_nodes[$];
    set_result_t expected_sets[$];
    int mismatches = 0;
    int send_idle_pct = 0, recv_stall_pct = 0;
    int hold_off_cycles = 0;
    logic s_tready_q = 0;

    function automatic bit heavier(int a, int b);
        if (node_w[a] != node_w[b]) return node_w[a] > node_w[b];
        return a < b;
    endfunction

    task automatic predict_node(node_req_t r);
        int order[NODES];
        int n, rank;
        logic [63:0] in_use, chosen, edges;
        logic [SUM_W-1:0] sum;
        logic signed [COST_W-1:0] cost;
        set_result_t res;
        if (stored_nodes < NODES) begin
            node_w[stored_nodes] = r.weight;
            node_row[stored_nodes] = r.row;
            stored_nodes++;
        end
        if (!r.last) return;
        n = stored_nodes;
        stored_nodes = 0;
        for (int i = 0; i < n; i++) begin
            rank = 0;
            for (int j = 0; j < n; j++)
                if (j != i && heavier(j, i)) rank++;
            order[rank] = i;
        end
        in_use = (n >= 64) ? '1 : ((64'd1 << n) - 1);
        chosen = '0;
        sum = '0;
        for (int k = 0; k < n; k++) begin
            edges = node_row[order[k]] & in_use & ~(64'd1 << order[k]);
            if ((edges & chosen) == 0) begin
                chosen[order[k]] = 1'b1;
                sum += node_w[order[k]];
            end
        end
        cost = $signed({1'b0, ONE_Q24}) - $signed({1'b0, sum});
        if (cost >= cost_limit) begin
            res = '{found: 1'b0, node: '0, cost: cost, last: 1'b1};
            expected_sets = {expected_sets, res};
        end else begin
            for (int k = 0; k < n; k++)
                if (chosen[order[k]]) begin
                    res = '{found: 1'b1, node: order[k][5:0], cost: cost, last: 1'b0};
                    expected_sets = {expected_sets, res};
                end
            expected_sets[expected_sets.size()-1].last = 1'b1;
        end
    endtask

    // driver
    always @(negedge aclk) begin
        node_req_t r;
        if (aresetn) begin
            if (!s_tvalid || s_tready_q) begin
                if (pending_nodes.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    r = pending_nodes[0];
                    s_tvalid <= 1'b1;
                    s_tdata <= {r.row, r.weight};
                    s_tlast <= r.last;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
            if (hold_off_cycles > 0) m_tready <= 1'b0;
            else m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // request acceptance, sampled at the rising edge
    always @(posedge aclk) begin
        s_tready_q <= aresetn && s_tvalid && s_tready;
        if (aresetn && s_tvalid && s_tready)
            predict_node(pending_nodes.pop_front());
    end

    always @(posedge aclk)
        if (hold_off_cycles > 0) hold_off_cycles <= hold_off_cycles - 1;

    // monitor
    always @(posedge aclk) begin
        set_result_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got = '{found: m_tuser, node: m_tdata[5:0], cost: m_tdata[44:6], last: m_tlast};
            if (expected_sets.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %p", got);
            end else begin
                want = expected_sets.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10) $display("mismatch: expected %p actual %p", want, got);
                end
            end
        end
    end

    task automatic write_limit(logic signed [31:0] v);
        @(negedge aclk);
        psel <= 1; pwrite <= 1; paddr <= THRESH_ADDR; pwdata <= v;
        @(negedge aclk);
        penable <= 1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        cost_limit = v;
        @(negedge aclk);
        psel <= 0; penable <= 0; pwrite <= 0;
    endtask

    task automatic wait_drained();
        while (pending_nodes.size() > 0 || s_tvalid || expected_sets.size() > 0)
            @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    // graph of n nodes; dense picks edge density
    task automatic queue_graph(int n, int dense, bit wide_weights);
        node_req_t r;
        for (int i = 0; i < n; i++) begin
            r.weight = wide_weights ? $urandom : $urandom_range(32'h0100_0000, 0);
            if ($urandom_range(3) == 0) r.weight = 32'h0080_0000;
            r.row = {$urandom, $urandom};
            if (dense == 0) r.row = r.row & {$urandom, $urandom} & {$urandom, $urandom};
            if (dense == 2) r.row = r.row | {$urandom, $urandom};
            r.last = (i == n - 1);
            pending_nodes = {pending_nodes, r};
        end
    endtask

    task automatic push_node(logic [31:0] w, logic [63:0] row, logic last);
        node_req_t r;
        r = '{weight: w, row: row, last: last};
        pending_nodes = {pending_nodes, r};
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1;
        // directed: single node, ties, full-range weights, diagonal, forward edges
        push_node(32'd0, 64'h0, 1'b1);
        push_node(32'hFFFF_FFFF, 64'h1, 1'b1);
        push_node(32'h0100_0000, 64'h2, 1'b0);
        push_node(32'h0100_0000, 64'h1, 1'b1);
        push_node(32'h0200_0000, 64'h0, 1'b0);
        push_node(32'h0300_0000, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
        push_node(32'h0100_0000, 64'h0, 1'b1);
        push_node(32'h0000_0001, 64'h0, 1'b0);
        push_node(32'h0000_0001, 64'hFFFF_FFFF_FFFF_FFFE, 1'b1);
        wait_drained();
        write_limit(32'sh7FFF_FFFF);
        push_node(32'h0, 64'h0, 1'b1);
        push_node(32'hFFFF_FFFF, 64'h0, 1'b0);
        push_node(32'hFFFF_FFFF, 64'h0, 1'b1);
        // store full: 70 nodes, overflow dropped, last still solves
        for (int i = 0; i < 70; i++)
            push_node($urandom, {$urandom, $urandom}, i == 69);
        wait_drained();
        write_limit(32'sh8000_0000);
        queue_graph(3, 1, 1);
        wait_drained();
        write_limit(32'sd0);
        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct = (ph == 1 || ph == 3) ? 83 : 0;
            recv_stall_pct = (ph == 2) ? 83 : (ph == 3 ? 26 : 0);
            if (ph == 3) send_idle_pct = 26;
            for (int g = 0; g < 6; g++) begin
                int n;
                n = (ph == 0 && g == 0) ? 64 : $urandom_range(8, 1);
                queue_graph(n, $urandom_range(2), $urandom_range(1));
                if (g == 2 && ph == 0) hold_off_cycles = 300;
            end
            wait_drained();
            send_idle_pct = 0; recv_stall_pct = 0;
            case (ph)
                0: write_limit(32'sh0100_0000);
                1: write_limit(-32'sd17);
                2: write_limit($urandom);
                default: ;
            endcase
        end
        wait_drained();
        if (mismatches == 0 && expected_sets.size() == 0)
            $display("greedy_max_weight_independent_set_tb passed");
        else
            $display("greedy_max_weight_independent_set_tb failed");
        $finish;
    end

    initial begin
        #20ms;
        $display("greedy_max_weight_independent_set_tb failed");
        $finish;
    end
endmodule
